/* design/gdnc_pkg.sv */
// Package for the Gregorian day number converter: payload structs, opcodes,
// calendar constants, the month tables and the small helper functions.
// Depends on nothing; every design file refers to it by scoped names.
package gdnc_pkg;

	// Operation selector carried in every request
	typedef enum logic {
		OP_TO_DATE   = 1'b0,
		OP_TO_DAYNUM = 1'b1
	} gdnc_op_t;

	typedef struct packed {
		gdnc_op_t    opcode;
		logic [21:0] absolute_day;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
	} gdnc_in_t;

	typedef struct packed {
		logic [21:0] out_absolute_day;
		logic [4:0]  out_day;
		logic [3:0]  out_month;
		logic [13:0] out_year;
		logic [8:0]  day_of_year;
		logic [2:0]  weekday;
	} gdnc_out_t;

	// Cycle lengths in days
	localparam logic [17:0] Days400 = 18'd146097;
	localparam logic [15:0] Days100 = 16'd36524;
	localparam logic [10:0] Days4   = 11'd1461;
	localparam logic [8:0]  Days1   = 9'd365;

	// Cycle lengths in years
	localparam logic [8:0] Years400     = 9'd400;
	localparam logic [6:0] YearsPerCent = 7'd100;

	// Shorter cycles in one longer cycle (centuries per 400 years, years per 4)
	localparam int SubCycles = 4;
	// Index of the last 4-year cycle in a century
	localparam logic [4:0] LastQuad = 5'd24;

	// Reciprocals for quotient estimates: floor(2^k / divisor)
	localparam logic [4:0] Rcp400 = 5'd28;   // k = 22
	localparam logic [5:0] Rcp4   = 6'd44;   // k = 16
	localparam logic [7:0] Rcp100 = 8'd163;  // k = 14

	// Multiple of 7 that lifts any signed day number into the non-negative range
	localparam logic [8:0] WeekBias = 9'd399;

	localparam logic [3:0] MonJan     = 4'd1;
	localparam logic [3:0] MonFeb     = 4'd2;
	localparam logic [3:0] MonDec     = 4'd12;
	localparam logic [4:0] DecLastDay = 5'd31;
	localparam logic [8:0] DoyLeapEnd = 9'd366;

	// Days before the first of each month in a common year
	localparam logic [8:0] MonthStart [12] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	// 31*(m-1), less (23+4m)/10 for m > 2; two's complement, any 4-bit month
	function automatic logic [10:0] ord_base(input logic [3:0] m);
		logic [10:0] r;
		case (m)
			4'd0:  r = -11'sd31;
			4'd1:  r = 11'd0;
			4'd2:  r = 11'd31;
			4'd3:  r = 11'd59;
			4'd4:  r = 11'd90;
			4'd5:  r = 11'd120;
			4'd6:  r = 11'd151;
			4'd7:  r = 11'd181;
			4'd8:  r = 11'd212;
			4'd9:  r = 11'd243;
			4'd10: r = 11'd273;
			4'd11: r = 11'd304;
			4'd12: r = 11'd334;
			4'd13: r = 11'd365;
			4'd14: r = 11'd396;
			default: r = 11'd426;
		endcase
		return r;
	endfunction

	// Residue modulo 7 by folding octal digits (8 is 1 modulo 7)
	function automatic logic [2:0] mod7(input logic [23:0] v);
		logic [5:0] s1;
		logic [3:0] s2;
		logic [3:0] s3;
		s1 = '0;
		for (int i = 0; i < 8; i++) begin
			s1 = s1 + 6'(v[3*i +: 3]);
		end
		s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
		s3 = 4'(s2[3]) + 4'(s2[2:0]);
		return (s3 >= 4'd7) ? 3'(s3 - 4'd7) : s3[2:0];
	endfunction

endpackage

/* design/gregorian_day_number_convert.sv */
// Gregorian day number converter, top level: seven-stage pipeline for both
// directions of the conversion. Depends on gdnc_pkg (types, constants, tables).
//
//   channel | payload            | handshake                 | accepted when
//   --------+--------------------+---------------------------+---------------------
//   cmd     | gdnc_pkg::gdnc_in_t  | cmd_valid in, cmd_stall out | cmd_valid && !cmd_stall
//   rsp     | gdnc_pkg::gdnc_out_t | rsp_valid out, rsp_stall in | rsp_valid && !rsp_stall
//
// A new transaction can enter each cycle while cmd_stall is low. The depth comes
// from the chained constant divisions on the day number (reciprocal estimate plus
// one correction for 400 and 4 years, compare ladders for centuries and for years)
// and the month search.
// arst_n clears the valid bits only; payload registers load without reset.
// A stage holds only while it and every later stage are full and rsp is stalled.
module gregorian_day_number_convert (
	input  logic                clk,
	input  logic                arst_n,
	input  gdnc_pkg::gdnc_in_t  cmd,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	output gdnc_pkg::gdnc_out_t rsp,
	output logic                rsp_valid,
	input  logic                rsp_stall
);

	// Stage 1: first 400-year quotient estimate, year split estimates, month base
	typedef struct packed {
		gdnc_pkg::gdnc_in_t pkt;
		logic        zero;
		logic [21:0] d0;
		logic [4:0]  n400e;
		logic        yzero;
		logic [13:0] ym1;
		logic [7:0]  q100e;
		logic [7:0]  y100e;
		logic [10:0] ord0;
		logic        mgt2;
	} st1_t;

	// Stage 2: 400-year count settled, century counts settled
	typedef struct packed {
		gdnc_pkg::gdnc_in_t pkt;
		logic        zero;
		logic [4:0]  n400;
		logic [17:0] d1;
		logic        yzero;
		logic [13:0] ym1;
		logic [7:0]  q100;
		logic [7:0]  y100;
		logic        ymz;
		logic [10:0] ord0;
		logic        mgt2;
	} st2_t;

	// Stage 3: century count, leap flag and day totals of prior years
	typedef struct packed {
		gdnc_pkg::gdnc_in_t pkt;
		logic        zero;
		logic [4:0]  n400;
		logic [2:0]  n100;
		logic [15:0] d2;
		logic        yzero;
		logic        leap1;
		logic [11:0] pre;
		logic [22:0] days;
		logic [10:0] ord0;
		logic        mgt2;
	} st3_t;

	// Stage 4: 4-year estimate; signed day number ready for both directions
	typedef struct packed {
		gdnc_pkg::gdnc_in_t pkt;
		logic        zero;
		logic [4:0]  n400;
		logic [2:0]  n100;
		logic [4:0]  n4e;
		logic [15:0] d2;
		logic [10:0] doy1;
		logic [23:0] sabs;
	} st4_t;

	// Stage 5: 4-year count settled, weekday
	typedef struct packed {
		gdnc_pkg::gdnc_in_t pkt;
		logic        zero;
		logic [4:0]  n400;
		logic [2:0]  n100;
		logic [4:0]  n4;
		logic [10:0] d3;
		logic [10:0] doy1;
		logic [23:0] sabs;
		logic [2:0]  wd;
	} st5_t;

	// Stage 6: year, day within the year, leap and year-end flags
	typedef struct packed {
		gdnc_pkg::gdnc_in_t pkt;
		logic        zero;
		logic [13:0] year0;
		logic [8:0]  rem;
		logic        leap0;
		logic        special;
		logic [10:0] doy1;
		logic [23:0] sabs;
		logic [2:0]  wd;
	} st6_t;

	st1_t st1_d, st_s1;
	st2_t st2_d, st_s2;
	st3_t st3_d, st_s3;
	st4_t st4_d, st_s4;
	st5_t st5_d, st_s5;
	st6_t st6_d, st_s6;
	gdnc_pkg::gdnc_out_t out_d, out_s7;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6, adv_s7;

	// Scratch products and remainders
	logic [26:0] p400;
	logic [21:0] pq;
	logic [21:0] py;
	logic [21:0] r400;
	logic        ge400;
	logic [14:0] rq;
	logic [14:0] ry;
	logic        geq;
	logic        gey;
	logic [21:0] p4;
	logic [23:0] base;
	logic [15:0] r4;
	logic        ge4;
	logic [2:0]  n1;
	logic [13:0] yy0;
	logic [3:0]  mcnt;
	logic [8:0]  mstart;

	// ---------------------------------------------------------------------
	// Flow control: a stage advances when it is empty or its successor
	// advances; this squeezes bubbles out while the response side stalls.
	// ---------------------------------------------------------------------
	assign adv_s7 = !vld_s7 || !rsp_stall;
	assign adv_s6 = !vld_s6 || adv_s7;
	assign adv_s5 = !vld_s5 || adv_s6;
	assign adv_s4 = !vld_s4 || adv_s5;
	assign adv_s3 = !vld_s3 || adv_s4;
	assign adv_s2 = !vld_s2 || adv_s3;
	assign adv_s1 = !vld_s1 || adv_s2;

	assign cmd_stall = !adv_s1;
	assign rsp_valid = vld_s7;
	assign rsp       = out_s7;

	// ---------------------------------------------------------------------
	// Stage 1. Day number path: d0 = day - 1 and a 400-year quotient that is
	// exact or one low. Date path: previous year, century estimates for it
	// and for the year itself, and the day of year without the leap day.
	// ---------------------------------------------------------------------
	always_comb begin
		st1_d       = '0;
		st1_d.pkt   = cmd;
		st1_d.zero  = (cmd.absolute_day == '0);
		st1_d.d0    = cmd.absolute_day - 22'd1;
		p400        = 27'(st1_d.d0) * 27'(gdnc_pkg::Rcp400);
		st1_d.n400e = p400[26:22];
		st1_d.yzero = (cmd.year == '0);
		st1_d.ym1   = st1_d.yzero ? '0 : cmd.year - 14'd1;
		pq          = 22'(st1_d.ym1) * 22'(gdnc_pkg::Rcp100);
		st1_d.q100e = pq[21:14];
		py          = 22'(cmd.year) * 22'(gdnc_pkg::Rcp100);
		st1_d.y100e = py[21:14];
		st1_d.ord0  = {6'd0, cmd.day} + gdnc_pkg::ord_base(cmd.month);
		st1_d.mgt2  = (cmd.month > gdnc_pkg::MonFeb);
	end

	// ---------------------------------------------------------------------
	// Stage 2. Correct each estimate with one compare and subtract.
	// ---------------------------------------------------------------------
	always_comb begin
		st2_d       = '0;
		st2_d.pkt   = st_s1.pkt;
		st2_d.zero  = st_s1.zero;
		r400        = st_s1.d0 - 22'(st_s1.n400e) * 22'(gdnc_pkg::Days400);
		ge400       = (r400 >= 22'(gdnc_pkg::Days400));
		st2_d.n400  = st_s1.n400e + 5'(ge400);
		st2_d.d1    = ge400 ? 18'(r400 - 22'(gdnc_pkg::Days400)) : 18'(r400);

		rq          = 15'(st_s1.ym1) - 15'(st_s1.q100e) * 15'(gdnc_pkg::YearsPerCent);
		geq         = (rq >= 15'(gdnc_pkg::YearsPerCent));
		st2_d.q100  = st_s1.q100e + 8'(geq);
		ry          = 15'(st_s1.pkt.year) - 15'(st_s1.y100e) * 15'(gdnc_pkg::YearsPerCent);
		gey         = (ry >= 15'(gdnc_pkg::YearsPerCent));
		st2_d.y100  = st_s1.y100e + 8'(gey);
		// year is a whole number of centuries
		st2_d.ymz   = (ry == '0) || (ry == 15'(gdnc_pkg::YearsPerCent));

		st2_d.yzero = st_s1.yzero;
		st2_d.ym1   = st_s1.ym1;
		st2_d.ord0  = st_s1.ord0;
		st2_d.mgt2  = st_s1.mgt2;
	end

	// ---------------------------------------------------------------------
	// Stage 3. Century count by a four-way compare ladder. Date path: leap
	// flag, leap days of prior years, 365 days per prior year.
	// ---------------------------------------------------------------------
	always_comb begin
		st3_d       = '0;
		st3_d.pkt   = st_s2.pkt;
		st3_d.zero  = st_s2.zero;
		st3_d.n400  = st_s2.n400;
		for (int k = 1; k <= gdnc_pkg::SubCycles; k++) begin
			if (st_s2.d1 >= 18'(k * gdnc_pkg::Days100)) begin
				st3_d.n100 = 3'(k);
			end
		end
		st3_d.d2    = 16'(st_s2.d1 - 18'(st3_d.n100) * 18'(gdnc_pkg::Days100));

		st3_d.yzero = st_s2.yzero;
		st3_d.leap1 = (st_s2.pkt.year[1:0] == 2'b00) &&
			(!st_s2.ymz || (st_s2.y100[1:0] == 2'b00));
		st3_d.pre   = 12'(st_s2.ym1 >> 2) - 12'(st_s2.q100) + 12'(st_s2.q100 >> 2);
		st3_d.days  = 23'(st_s2.ym1) * 23'(gdnc_pkg::Days1);
		st3_d.ord0  = st_s2.ord0;
		st3_d.mgt2  = st_s2.mgt2;
	end

	// ---------------------------------------------------------------------
	// Stage 4. 4-year quotient estimate. Date path: final day of year and
	// the signed day number; year zero counts as one year back.
	// ---------------------------------------------------------------------
	always_comb begin
		st4_d      = '0;
		st4_d.pkt  = st_s3.pkt;
		st4_d.zero = st_s3.zero;
		st4_d.n400 = st_s3.n400;
		st4_d.n100 = st_s3.n100;
		st4_d.d2   = st_s3.d2;
		p4         = 22'(st_s3.d2) * 22'(gdnc_pkg::Rcp4);
		st4_d.n4e  = p4[20:16];
		st4_d.doy1 = st_s3.ord0 + 11'(st_s3.leap1 && st_s3.mgt2);
		base       = st_s3.yzero ? (24'd0 - 24'(gdnc_pkg::Days1)) :
			(24'(st_s3.days) + 24'(st_s3.pre));
		case (st_s3.pkt.opcode)
			gdnc_pkg::OP_TO_DATE:   st4_d.sabs = 24'(st_s3.pkt.absolute_day);
			gdnc_pkg::OP_TO_DAYNUM: st4_d.sabs = {{13{st4_d.doy1[10]}}, st4_d.doy1} + base;
			default:                st4_d.sabs = 24'(st_s3.pkt.absolute_day);
		endcase
	end

	// ---------------------------------------------------------------------
	// Stage 5. Settle the 4-year count; weekday from the shared mod-7 fold.
	// ---------------------------------------------------------------------
	always_comb begin
		st5_d      = '0;
		st5_d.pkt  = st_s4.pkt;
		st5_d.zero = st_s4.zero;
		st5_d.n400 = st_s4.n400;
		st5_d.n100 = st_s4.n100;
		r4         = st_s4.d2 - 16'(st_s4.n4e) * 16'(gdnc_pkg::Days4);
		ge4        = (r4 >= 16'(gdnc_pkg::Days4));
		st5_d.n4   = st_s4.n4e + 5'(ge4);
		st5_d.d3   = ge4 ? 11'(r4 - 16'(gdnc_pkg::Days4)) : 11'(r4);
		st5_d.doy1 = st_s4.doy1;
		st5_d.sabs = st_s4.sabs;
		st5_d.wd   = gdnc_pkg::mod7(st_s4.sabs + 24'(gdnc_pkg::WeekBias)) + 3'd1;
	end

	// ---------------------------------------------------------------------
	// Stage 6. Year count by compare ladder, day within the year, and the
	// last-day-of-cycle case (a fourth century or a fourth year).
	// ---------------------------------------------------------------------
	always_comb begin
		st6_d      = '0;
		st6_d.pkt  = st_s5.pkt;
		st6_d.zero = st_s5.zero;
		n1         = '0;
		for (int k = 1; k <= gdnc_pkg::SubCycles; k++) begin
			if (st_s5.d3 >= 11'(k * gdnc_pkg::Days1)) begin
				n1 = 3'(k);
			end
		end
		st6_d.rem  = 9'(st_s5.d3 - 11'(n1) * 11'(gdnc_pkg::Days1)) + 9'd1;
		yy0        = 14'(st_s5.n400) * 14'(gdnc_pkg::Years400) +
			14'(st_s5.n100) * 14'(gdnc_pkg::YearsPerCent) +
			{7'd0, st_s5.n4, 2'b00} + 14'(n1);
		st6_d.special = (st_s5.n100 == 3'(gdnc_pkg::SubCycles)) ||
			(n1 == 3'(gdnc_pkg::SubCycles));
		// next year is leap when it closes a 4-year cycle, except at a
		// century boundary that does not close a 400-year cycle
		st6_d.leap0 = st6_d.special ||
			((n1 == 3'(gdnc_pkg::SubCycles - 1)) &&
			!((st_s5.n4 == gdnc_pkg::LastQuad) &&
			(st_s5.n100 != 3'(gdnc_pkg::SubCycles - 1))));
		st6_d.year0 = st6_d.special ? yy0 : yy0 + 14'd1;
		st6_d.doy1  = st_s5.doy1;
		st6_d.sabs  = st_s5.sabs;
		st6_d.wd    = st_s5.wd;
	end

	// ---------------------------------------------------------------------
	// Stage 7. Month search over the eleven month starts, then pick the
	// fields for the response.
	// ---------------------------------------------------------------------
	always_comb begin
		mcnt = '0;
		for (int i = 1; i < 12; i++) begin
			if (st_s6.rem > gdnc_pkg::MonthStart[i] + 9'(st_s6.leap0 && (i >= 2))) begin
				mcnt = mcnt + 4'd1;
			end
		end
		mstart = gdnc_pkg::MonthStart[mcnt] + 9'(st_s6.leap0 && (mcnt >= 4'd2));

		out_d         = '0;
		out_d.weekday = st_s6.wd;
		case (st_s6.pkt.opcode)
			gdnc_pkg::OP_TO_DATE: begin
				out_d.out_absolute_day = st_s6.pkt.absolute_day;
				if (st_s6.zero) begin
					out_d.out_day     = '0;
					out_d.out_month   = gdnc_pkg::MonJan;
					out_d.out_year    = 14'd1;
					out_d.day_of_year = '0;
				end else if (st_s6.special) begin
					out_d.out_day     = gdnc_pkg::DecLastDay;
					out_d.out_month   = gdnc_pkg::MonDec;
					out_d.out_year    = st_s6.year0;
					out_d.day_of_year = gdnc_pkg::DoyLeapEnd;
				end else begin
					out_d.out_day     = 5'(st_s6.rem - mstart);
					out_d.out_month   = mcnt + 4'd1;
					out_d.out_year    = st_s6.year0;
					out_d.day_of_year = st_s6.rem;
				end
			end
			default: begin
				out_d.out_absolute_day = st_s6.sabs[21:0];
				out_d.out_day          = st_s6.pkt.day;
				out_d.out_month        = st_s6.pkt.month;
				out_d.out_year         = st_s6.pkt.year;
				out_d.day_of_year      = st_s6.doy1[8:0];
			end
		endcase
	end

	// Valid bits: advance with their stage, clear on reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= cmd_valid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
			if (adv_s4) vld_s4 <= vld_s3;
			if (adv_s5) vld_s5 <= vld_s4;
			if (adv_s6) vld_s6 <= vld_s5;
			if (adv_s7) vld_s7 <= vld_s6;
		end
	end

	// Payload registers: load on advance, hold otherwise
	always_ff @(posedge clk) begin
		if (adv_s1) st_s1  <= st1_d;
		if (adv_s2) st_s2  <= st2_d;
		if (adv_s3) st_s3  <= st3_d;
		if (adv_s4) st_s4  <= st4_d;
		if (adv_s5) st_s5  <= st5_d;
		if (adv_s6) st_s6  <= st6_d;
		if (adv_s7) out_s7 <= out_d;
	end

	// ---------------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------------

	// Back pressure reaches the request side only with every stage full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6 &&
		vld_s7 && rsp_stall))
		else $error("request stalled with a free pipeline stage");

	// An accepted transaction lands in stage 1
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> vld_s1)
		else $error("accepted transaction missing from stage 1");

	// Corrected remainders stay below their divisors
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && (st_s2.pkt.opcode == gdnc_pkg::OP_TO_DATE)) |->
		(st_s2.d1 < gdnc_pkg::Days400))
		else $error("400-year remainder out of range");

	a_rem4_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s5 && (st_s5.pkt.opcode == gdnc_pkg::OP_TO_DATE)) |->
		(st_s5.d3 < gdnc_pkg::Days4))
		else $error("4-year remainder out of range");

	// Day within an ordinary year lies in 1..365
	a_doy_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s6 && (st_s6.pkt.opcode == gdnc_pkg::OP_TO_DATE) && !st_s6.zero &&
		!st_s6.special) |-> ((st_s6.rem != '0) && (st_s6.rem <= gdnc_pkg::Days1)))
		else $error("day within year out of range");

endmodule
